// ===== hw/rtl/substring_search_stream_assert.svh =====
// assertion macros for the substring search stream block
`ifndef SUBSTRING_SEARCH_STREAM_ASSERT_SVH
`define SUBSTRING_SEARCH_STREAM_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SSS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sss assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define SSS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sss assertion failed");

`endif

// ===== hw/rtl/sss_pkg.sv =====
// types, constants and byte compare function shared by the substring search block
package sss_pkg;

	localparam int NEEDLE_BYTES = 16;
	localparam int POS_W        = 16;
	localparam int LEN_W        = 5;
	localparam int ADDR_W       = 5;
	localparam int DATA_W       = 64;

	localparam logic [7:0] FOLD_BIT = 8'h20;
	localparam logic [7:0] LOWER_A  = 8'h61;
	localparam logic [7:0] LOWER_Z  = 8'h7a;

	typedef enum logic [1:0] {
		REG_NEEDLE_LOW    = 2'd0,
		REG_NEEDLE_HIGH   = 2'd1,
		REG_NEEDLE_LENGTH = 2'd2,
		REG_CASE_FOLD     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       last_byte;
	} text_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] match_position;
		logic             position_overflow;
	} result_t;

	typedef struct packed {
		logic [NEEDLE_BYTES-1:0][7:0] needle;
		logic [LEN_W-1:0]             needle_length;
		logic                         case_fold;
	} cfg_t;

	function automatic logic byte_eq(input logic [7:0] t, input logic [7:0] n,
		input logic fold);
		logic [7:0] lt;
		logic [7:0] ln;
		lt = t | FOLD_BIT;
		ln = n | FOLD_BIT;
		return (t == n) || (fold && (lt == ln) && (lt >= LOWER_A) && (lt <= LOWER_Z));
	endfunction

endpackage

// ===== hw/rtl/sss_match.sv =====
// parallel window compare: needle length, match hit and start position
module sss_match #(
	parameter int LIM        = 16,
	parameter int WIN        = 15,
	parameter int INDEX_BITS = 16
) (
	input  sss_pkg::cfg_t          cfg,
	input  logic [7:0]             text_byte,
	input  logic [WIN-1:0][7:0]    window,
	input  logic [INDEX_BITS-1:0]  pos,
	input  logic                   sat,
	output logic                   hit,
	output logic [INDEX_BITS-1:0]  start
);

	localparam int PW = ((INDEX_BITS > sss_pkg::LEN_W) ? INDEX_BITS : sss_pkg::LEN_W) + 1;

	logic [sss_pkg::LEN_W-1:0]                  lim;
	logic [sss_pkg::LEN_W-1:0]                  nlen;
	logic [sss_pkg::NEEDLE_BYTES-1:0][7:0]      w;
	logic [sss_pkg::NEEDLE_BYTES-1:0]           ok;
	logic [3:0]                                 sel;
	logic                                       enough;

	always_comb begin
		lim = (cfg.needle_length > sss_pkg::LEN_W'(LIM)) ? sss_pkg::LEN_W'(LIM)
			: cfg.needle_length;
		nlen = lim;
		for (int k = sss_pkg::NEEDLE_BYTES - 1; k >= 0; k--) begin
			if ((sss_pkg::LEN_W'(k) < lim) && (cfg.needle[k] == 8'h00)) begin
				nlen = sss_pkg::LEN_W'(k);
			end
		end
	end

	always_comb begin
		w[0] = text_byte;
		for (int j = 1; j < sss_pkg::NEEDLE_BYTES; j++) begin
			if (j <= WIN) begin
				w[j] = window[j-1];
			end else begin
				w[j] = 8'h00;
			end
		end
	end

	always_comb begin
		sel = '0;
		for (int k = 0; k < sss_pkg::NEEDLE_BYTES; k++) begin
			sel = 4'(nlen - sss_pkg::LEN_W'(k) - sss_pkg::LEN_W'(1));
			ok[k] = !(sss_pkg::LEN_W'(k) < nlen)
				|| sss_pkg::byte_eq(w[sel], cfg.needle[k], cfg.case_fold);
		end
	end

	// empty needle always starts at zero
	assign enough = sat || ((PW'(pos) + PW'(1)) >= PW'(nlen));
	assign hit    = (nlen == '0) || ((text_byte != 8'h00) && enough && (&ok));
	assign start  = (nlen == '0) ? '0
		: sat ? '1 : (pos - INDEX_BITS'(nlen - sss_pkg::LEN_W'(1)));

endmodule

// ===== hw/rtl/substring_search_stream.sv =====
// substring search stream: top level with config registers, input stage and result register
//
// Streams one text byte per transfer on the text channel (valid/ready) and returns one
// result per buffer on the result channel (valid/ready). A buffer ends at its byte with
// last_byte set; a zero text byte, a match or the final byte produces the result, and
// later bytes of that buffer only advance state until the final byte.
// The needle, its length and case folding are written over APB, by the user only while
// idle (unenforced): regs at byte addresses 0, 8, 16, 24, 64-bit data, pready always high.
// Throughput: one text byte per cycle unless a result waits unaccepted; the window compare
// against all needle bytes is one combinational pass from the input stage to the result
// register. An accepted byte waits in the input stage and its result (if any) is loaded
// into the result register when that stage fires, and is shown from then on.
// Receiver stall: while a result waits unaccepted, the input stage holds its byte and
// text_ready drops once that stage is full; nothing is lost or repeated.
// Reset: clears the registers to zero, the byte window, position and search state;
// no result is pending after reset.
module substring_search_stream #(
	parameter int MAX_NEEDLE = 16,
	parameter int INDEX_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        text_valid,
	output logic                        text_ready,
	input  sss_pkg::text_t              text,
	output logic                        result_valid,
	input  logic                        result_ready,
	output sss_pkg::result_t            result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sss_pkg::ADDR_W-1:0]  paddr,
	input  logic [sss_pkg::DATA_W-1:0]  pwdata,
	output logic [sss_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);

	`include "substring_search_stream_assert.svh"

	localparam int LIM  = (MAX_NEEDLE < sss_pkg::NEEDLE_BYTES) ? MAX_NEEDLE
		: sss_pkg::NEEDLE_BYTES;
	localparam int WIN  = (LIM > 1) ? LIM - 1 : 1;
	localparam int IDXW = (INDEX_BITS > sss_pkg::POS_W) ? INDEX_BITS : sss_pkg::POS_W;

	sss_pkg::cfg_t             cfg_q;
	sss_pkg::reg_idx_t         reg_idx;
	logic                      cfg_wr;

	sss_pkg::text_t            text_s1;
	logic                      valid_s1;
	logic                      fire;

	logic [WIN-1:0][7:0]       window_q;
	logic [INDEX_BITS-1:0]     byte_idx_q;
	logic                      sat_q;
	logic                      done_q;

	logic                      hit;
	logic [INDEX_BITS-1:0]     start;
	logic [IDXW-1:0]           start_ext;
	logic                      emit;

	logic                      result_valid_q;
	sss_pkg::result_t          result_q;

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = sss_pkg::reg_idx_t'(paddr[4:3]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				sss_pkg::REG_NEEDLE_LOW:    cfg_q.needle[7:0]     <= pwdata;
				sss_pkg::REG_NEEDLE_HIGH:   cfg_q.needle[15:8]    <= pwdata;
				sss_pkg::REG_NEEDLE_LENGTH: cfg_q.needle_length   <= pwdata[sss_pkg::LEN_W-1:0];
				sss_pkg::REG_CASE_FOLD:     cfg_q.case_fold       <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			sss_pkg::REG_NEEDLE_LOW:    prdata = cfg_q.needle[7:0];
			sss_pkg::REG_NEEDLE_HIGH:   prdata = cfg_q.needle[15:8];
			sss_pkg::REG_NEEDLE_LENGTH: prdata = sss_pkg::DATA_W'(cfg_q.needle_length);
			sss_pkg::REG_CASE_FOLD:     prdata = sss_pkg::DATA_W'(cfg_q.case_fold);
			default:                    prdata = '0;
		endcase
	end

	// input stage
	assign fire       = valid_s1 && (!result_valid_q || result_ready);
	assign text_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_valid && text_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && text_ready) begin
			text_s1 <= text;
		end
	end

	sss_match #(
		.LIM        (LIM),
		.WIN        (WIN),
		.INDEX_BITS (INDEX_BITS)
	) u_match (
		.cfg       (cfg_q),
		.text_byte (text_s1.text_byte),
		.window    (window_q),
		.pos       (byte_idx_q),
		.sat       (sat_q),
		.hit       (hit),
		.start     (start)
	);

	assign emit      = !done_q && (hit || (text_s1.text_byte == 8'h00) || text_s1.last_byte);
	assign start_ext = IDXW'(start);

	// buffer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= '0;
			byte_idx_q <= '0;
			sat_q      <= 1'b0;
			done_q     <= 1'b0;
		end else if (fire) begin
			if (text_s1.last_byte) begin
				window_q   <= '0;
				byte_idx_q <= '0;
				sat_q      <= 1'b0;
				done_q     <= 1'b0;
			end else begin
				window_q[0] <= text_s1.text_byte;
				for (int j = 1; j < WIN; j++) begin
					window_q[j] <= window_q[j-1];
				end
				if (byte_idx_q == '1) begin
					sat_q <= 1'b1;
				end else begin
					byte_idx_q <= byte_idx_q + INDEX_BITS'(1);
				end
				if (emit) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire && emit) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			result_q.found             <= hit;
			result_q.match_position    <= hit ? start_ext[sss_pkg::POS_W-1:0] : '0;
			result_q.position_overflow <= sat_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// checks
	`SSS_ASSERT_IMP(a_notfound_pos_zero, result_valid_q && !result_q.found,
		result_q.match_position == '0)
	`SSS_ASSERT_IMP(a_sat_at_max, sat_q, byte_idx_q == '1)
	`SSS_ASSERT_NXT(a_last_clears, fire && text_s1.last_byte,
		(byte_idx_q == '0) && !sat_q && !done_q)

endmodule
